FILE: rtl/core/url_percent_codec_top_assert.svh
// Assertion macros for the URL percent codec top level.
// Used only by url_percent_codec_top; expects clk and rst_n in scope.
`ifndef URL_PERCENT_CODEC_TOP_ASSERT_SVH
`define URL_PERCENT_CODEC_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define UPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/upc_pkg.sv
// Shared types, character constants and helper functions for the URL percent codec.
// No dependencies.
package upc_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    localparam logic [1:0] CFG_DECODE_MODE = 2'd0;
    localparam logic [1:0] CFG_PLUS_SPACE  = 2'd1;

    localparam logic [1:0] HOLD_NONE  = 2'd0;
    localparam logic [1:0] HOLD_PCT   = 2'd1;
    localparam logic [1:0] HOLD_DIGIT = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } upc_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } upc_out_t;

    // Escape bytes held back between input bytes while decoding.
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] hex_char;
    } upc_hold_t;

    // Results of one input byte; slot 0 goes out first.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
    } upc_group_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_unreserved(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A)) ||
               is_digit(b) || (b == 8'h2D) || (b == 8'h2E) || (b == 8'h5F) ||
               (b == 8'h7E) || (b == 8'h3D);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || ((b >= 8'h41) && (b <= 8'h46)) ||
               ((b >= 8'h61) && (b <= 8'h66));
    endfunction

    // Letters A-F and a-f have low nibble 1..6, so add nine.
    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [3:0] v;
        if (is_digit(b))
        begin
            v = b[3:0];
        end
        else if (is_hex(b))
        begin
            v = b[3:0] + 4'd9;
        end
        else
        begin
            v = 4'd0;
        end
        return v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        case (nib)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'hA: c = 8'h41;
            4'hB: c = 8'h42;
            4'hC: c = 8'h43;
            4'hD: c = 8'h44;
            4'hE: c = 8'h45;
            default: c = 8'h46;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/upc_xlate.sv
// Per-byte conversion: turns one input byte and the held escape state into
// up to three result bytes and the next held state. Depends on upc_pkg.
module upc_xlate (
    input  logic              [7:0] in_byte,
    input  logic                    in_last,
    input  logic                    decode_mode,
    input  logic                    plus_space,
    input  upc_pkg::upc_hold_t      hold,
    output upc_pkg::upc_hold_t      hold_next,
    output upc_pkg::upc_group_t     grp
);
    import upc_pkg::*;

    logic [3:0][7:0] slot;
    logic [1:0]      n;
    logic            fresh_pct;
    logic [7:0]      fresh_byte;
    logic            b_hex;

    assign fresh_pct  = (in_byte == PCT_CHAR);
    assign fresh_byte = ((in_byte == PLUS_CHAR) && plus_space) ? SPACE_CHAR : in_byte;
    assign b_hex      = is_hex(in_byte);

    always_comb
    begin
        slot      = '0;
        n         = 2'd0;
        hold_next = hold;
        if (!decode_mode)
        begin
            if (is_unreserved(in_byte))
            begin
                slot[0] = in_byte;
                n       = 2'd1;
            end
            else if ((in_byte == SPACE_CHAR) && plus_space)
            begin
                slot[0] = PLUS_CHAR;
                n       = 2'd1;
            end
            else
            begin
                slot[0] = PCT_CHAR;
                slot[1] = hex_char(in_byte[7:4]);
                slot[2] = hex_char(in_byte[3:0]);
                n       = 2'd3;
            end
        end
        else
        begin
            case (hold.count)
                HOLD_NONE:
                begin
                    if (fresh_pct)
                    begin
                        hold_next.count = HOLD_PCT;
                    end
                    else
                    begin
                        slot[0] = fresh_byte;
                        n       = 2'd1;
                    end
                end
                HOLD_PCT:
                begin
                    if (b_hex)
                    begin
                        hold_next.count    = HOLD_DIGIT;
                        hold_next.hex_char = in_byte;
                    end
                    else
                    begin
                        // broken escape: release the percent, then treat the byte afresh
                        slot[0] = PCT_CHAR;
                        n       = 2'd1;
                        if (fresh_pct)
                        begin
                            hold_next.count = HOLD_PCT;
                        end
                        else
                        begin
                            hold_next.count = HOLD_NONE;
                            slot[1]         = fresh_byte;
                            n               = 2'd2;
                        end
                    end
                end
                default:
                begin
                    if (b_hex)
                    begin
                        hold_next.count = HOLD_NONE;
                        slot[0]         = {hex_value(hold.hex_char), hex_value(in_byte)};
                        n               = 2'd1;
                    end
                    else
                    begin
                        slot[0] = PCT_CHAR;
                        slot[1] = hold.hex_char;
                        n       = 2'd2;
                        if (fresh_pct)
                        begin
                            hold_next.count = HOLD_PCT;
                        end
                        else
                        begin
                            hold_next.count = HOLD_NONE;
                            slot[2]         = fresh_byte;
                            n               = 2'd3;
                        end
                    end
                end
            endcase
        end

        // flush anything still held at the end of the string
        if (in_last)
        begin
            if (hold_next.count != HOLD_NONE)
            begin
                slot[n] = PCT_CHAR;
                n       = n + 2'd1;
            end
            if (hold_next.count == HOLD_DIGIT)
            begin
                slot[n] = hold_next.hex_char;
                n       = n + 2'd1;
            end
            hold_next = '0;
        end
    end

    assign grp.bytes = slot[2:0];
    assign grp.cnt   = n;
    assign grp.last  = in_last;

endmodule

FILE: rtl/core/url_percent_codec_top.sv
// The first result byte passes the input register, the result group register and the output register.
// Throughput: one result byte per cycle while the output is not stalled; an input byte
// occupies the single output channel once for each result byte that it yields.
// Reset (rst_n, async, active low): encode mode, plus/space mapping off, nothing
// held, all stages empty. Depends on upc_pkg, upc_xlate and the assert header.
`include "url_percent_codec_top_assert.svh"

module url_percent_codec_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  upc_pkg::upc_in_t    in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output upc_pkg::upc_out_t   out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic          [1:0] cfg_index,
    input  logic                cfg_data
);
    import upc_pkg::*;

    logic        decode_mode_reg;
    logic        plus_space_reg;
    upc_hold_t   hold_reg;

    logic        in_vld_reg;
    upc_in_t     in_data_reg;

    upc_group_t  grp_reg;
    upc_group_t  grp_next;
    upc_group_t  xlate_grp;
    upc_hold_t   xlate_hold;

    logic        out_vld_reg;
    upc_out_t    out_data_reg;

    logic        cfg_wr;
    logic        out_take;
    logic        move;
    logic        grp_free;
    logic        advance;
    logic        in_xfer;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign out_take = !out_vld_reg || !out_stall;
    assign move     = (grp_reg.cnt != 2'd0) && out_take;
    assign grp_free = (grp_reg.cnt == 2'd0) || ((grp_reg.cnt == 2'd1) && move);
    assign advance  = in_vld_reg && grp_free;
    assign in_stall = in_vld_reg && !grp_free;
    assign in_xfer  = in_valid && !in_stall;

    upc_xlate u_xlate (
        .in_byte     (in_data_reg.in_byte),
        .in_last     (in_data_reg.in_last),
        .decode_mode (decode_mode_reg),
        .plus_space  (plus_space_reg),
        .hold        (hold_reg),
        .hold_next   (xlate_hold),
        .grp         (xlate_grp)
    );

    // configuration and held escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg <= 1'b0;
            plus_space_reg  <= 1'b0;
            hold_reg        <= '0;
        end
        else
        begin
            if (cfg_wr && (cfg_index == CFG_DECODE_MODE))
            begin
                decode_mode_reg <= cfg_data;
                hold_reg        <= '0;
            end
            else if (advance)
            begin
                hold_reg <= xlate_hold;
            end
            if (cfg_wr && (cfg_index == CFG_PLUS_SPACE))
            begin
                plus_space_reg <= cfg_data;
            end
        end
    end

    // input register: hold while the result group cannot be replaced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_data_reg <= in_data;
        end
    end

    // result group: load from the converter, or shift one byte toward the output
    always_comb
    begin
        grp_next = grp_reg;
        if (advance)
        begin
            grp_next = xlate_grp;
        end
        else if (move)
        begin
            grp_next.bytes = {8'h00, grp_reg.bytes[2], grp_reg.bytes[1]};
            grp_next.cnt   = grp_reg.cnt - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_reg <= '0;
        end
        else
        begin
            grp_reg <= grp_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (move)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_data_reg.out_byte <= grp_reg.bytes[0];
            out_data_reg.out_last <= grp_reg.last && (grp_reg.cnt == 2'd1);
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    `UPC_ASSERT_NOW(a_enc_no_hold, !decode_mode_reg, hold_reg.count == HOLD_NONE, "hold in encode")
    `UPC_ASSERT_NEXT(a_move_fills_output, move, out_vld_reg, "output not loaded")
    `UPC_ASSERT_NEXT(a_in_hold, in_stall, in_vld_reg && $stable(in_data_reg), "input lost")

endmodule

FILE: tb/url_percent_codec_top_tb.sv
// Self-checking testbench for url_percent_codec_top: encode and decode of byte strings.
// Predicts every result byte and checks it against the output channel; needs upc_pkg.
`timescale 1ns / 1ps

module url_percent_codec_top_tb;
    import upc_pkg::*;

    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 500;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    upc_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    upc_out_t out_data;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [1:0] cfg_index;
    logic     cfg_data;

    // predicted codec state
    logic       decoding;
    logic       plus_map;
    logic [1:0] hold_cnt;
    logic [7:0] hold_char;

    upc_out_t   expected_q[$];
    logic [7:0] step_bytes[$];
    logic [7:0] text[$];
    int         errors;
    int         sent_items;
    logic       gaps_on;

    url_percent_codec_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic url_safe(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
               (b >= 8'h30 && b <= 8'h39) || b == 8'h2D || b == 8'h2E ||
               b == 8'h5F || b == 8'h7E || b == 8'h3D;
    endfunction

    function automatic logic hex_digit(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] b);
        logic [7:0] v;
        if (b <= 8'h39)
            v = b - 8'h30;
        else if (b <= 8'h46)
            v = b - 8'h37;
        else
            v = b - 8'h57;
        return v[3:0];
    endfunction

    function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + {4'h0, nib} : 8'h37 + {4'h0, nib};
    endfunction

    // Append one predicted byte for the current input.
    function automatic void add_step(input logic [7:0] b);
        step_bytes.insert(step_bytes.size(), b);
    endfunction

    function automatic void add_text(input logic [7:0] b);
        text.insert(text.size(), b);
    endfunction

    // Decode a byte with nothing held.
    function automatic void decode_plain(input logic [7:0] b);
        if (b == PCT_CHAR)
            hold_cnt = HOLD_PCT;
        else if (b == PLUS_CHAR && plus_map)
            add_step(SPACE_CHAR);
        else
            add_step(b);
    endfunction

    function automatic void predict_bytes(input logic [7:0] b, input logic last);
        upc_out_t r;
        step_bytes.delete();
        if (!decoding)
        begin
            if (url_safe(b))
            begin
                add_step(b);
            end
            else if (b == SPACE_CHAR && plus_map)
            begin
                add_step(PLUS_CHAR);
            end
            else
            begin
                add_step(PCT_CHAR);
                add_step(hex_glyph(b[7:4]));
                add_step(hex_glyph(b[3:0]));
            end
        end
        else if (hold_cnt == HOLD_NONE)
        begin
            decode_plain(b);
        end
        else if (hold_cnt == HOLD_PCT)
        begin
            if (hex_digit(b))
            begin
                hold_char = b;
                hold_cnt = HOLD_DIGIT;
            end
            else
            begin
                hold_cnt = HOLD_NONE;
                add_step(PCT_CHAR);
                decode_plain(b);
            end
        end
        else
        begin
            hold_cnt = HOLD_NONE;
            if (hex_digit(b))
            begin
                add_step({nibble_of(hold_char), nibble_of(b)});
            end
            else
            begin
                add_step(PCT_CHAR);
                add_step(hold_char);
                decode_plain(b);
            end
        end

        // flush whatever is held at the end of the string
        if (last)
        begin
            if (hold_cnt != HOLD_NONE)
                add_step(PCT_CHAR);
            if (hold_cnt == HOLD_DIGIT)
                add_step(hold_char);
            hold_cnt = HOLD_NONE;
            hold_char = 8'h00;
        end

        foreach (step_bytes[i])
        begin
            r.out_byte = step_bytes[i];
            r.out_last = last && (i == step_bytes.size() - 1);
            expected_q.insert(expected_q.size(), r);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_hex();
        logic [7:0] r;
        r = 8'($urandom_range(0, 21));
        if (r < 8'd10)
            return 8'h30 + r;
        else if (r < 8'd16)
            return 8'h37 + r;
        return 8'h51 + r;
    endfunction

    // Output side: random stall bursts, mostly short.
    initial
    begin
        int len;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (gaps_on && $urandom_range(0, 99) < 25)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (len) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        upc_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result byte %h last %b", $time,
                         out_data.out_byte, out_data.out_last);
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_data.out_byte !== want.out_byte)
                begin
                    errors++;
                    $display("%0t: out_byte expected %h actual %h", $time,
                             want.out_byte, out_data.out_byte);
                end
                if (out_data.out_last !== want.out_last)
                begin
                    errors++;
                    $display("%0t: out_last expected %b actual %b", $time,
                             want.out_last, out_data.out_last);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        in_data <= '{in_byte: b, in_last: last};
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        predict_bytes(b, last);
        sent_items++;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_text();
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    // Hold off until every expected byte is out and the pipeline is quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic val);
        settle();
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_DECODE_MODE)
        begin
            decoding = val;
            hold_cnt = HOLD_NONE;
            hold_char = 8'h00;
        end
        else if (idx == CFG_PLUS_SPACE)
        begin
            plus_map = val;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_encode_directed();
        write_reg(CFG_DECODE_MODE, 1'b0);
        write_reg(CFG_PLUS_SPACE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h7A, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(SPACE_CHAR, 1'b0);
        send_byte(PLUS_CHAR, 1'b1);
        write_reg(CFG_PLUS_SPACE, 1'b1);
        send_byte(SPACE_CHAR, 1'b1);
    endtask

    task automatic test_decode_directed();
        write_reg(CFG_DECODE_MODE, 1'b1);
        write_reg(CFG_PLUS_SPACE, 1'b1);
        // complete escapes, upper and lower case
        send_byte(PCT_CHAR, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h31, 1'b0);
        send_byte(PCT_CHAR, 1'b0);
        send_byte(8'h66, 1'b0);
        send_byte(8'h46, 1'b0);
        send_byte(PLUS_CHAR, 1'b0);
        // escape broken right after the percent, then after one digit
        send_byte(PCT_CHAR, 1'b0);
        send_byte(8'h47, 1'b0);
        send_byte(PCT_CHAR, 1'b0);
        send_byte(8'h37, 1'b0);
        send_byte(PCT_CHAR, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h64, 1'b1);
        // incomplete escapes flushed at end of string
        send_byte(PCT_CHAR, 1'b0);
        send_byte(8'h61, 1'b1);
        send_byte(PCT_CHAR, 1'b1);
        write_reg(CFG_PLUS_SPACE, 1'b0);
        send_byte(PLUS_CHAR, 1'b1);
    endtask

    task automatic test_config_while_held();
        write_reg(CFG_DECODE_MODE, 1'b1);
        send_byte(PCT_CHAR, 1'b0);
        send_byte(8'h34, 1'b0);
        // mode write drops the held escape
        write_reg(CFG_DECODE_MODE, 1'b1);
        send_byte(8'h31, 1'b1);
        send_byte(PCT_CHAR, 1'b0);
        write_reg(CFG_PLUS_SPACE, 1'b1);
        send_byte(PLUS_CHAR, 1'b1);
        send_byte(PCT_CHAR, 1'b0);
        send_byte(8'h34, 1'b0);
        // writes to unused indexes must leave everything alone
        write_reg(CFG_SPARE_LO, 1'b1);
        write_reg(CFG_SPARE_HI, 1'b0);
        send_byte(8'h31, 1'b1);
    endtask

    task automatic build_text(input logic dec);
        int len;
        int kind;
        text.delete();
        len = $urandom_range(1, 12);
        while (text.size() < len)
        begin
            kind = $urandom_range(0, 9);
            if (!dec)
            begin
                if (kind < 5)
                    add_text(8'($urandom_range(0, 255)));
                else if (kind < 8)
                    add_text(8'($urandom_range(8'h20, 8'h7E)));
                else
                    add_text(SPACE_CHAR);
            end
            else if (kind < 4)
            begin
                add_text(PCT_CHAR);
                add_text(rand_hex());
                add_text(rand_hex());
            end
            else if (kind == 4)
            begin
                add_text(PCT_CHAR);
                if ($urandom_range(0, 1))
                    add_text(rand_hex());
                add_text(8'($urandom_range(0, 255)));
            end
            else if (kind == 5)
                add_text(PLUS_CHAR);
            else if (kind == 6)
                add_text(SPACE_CHAR);
            else if (kind == 7)
                add_text(PCT_CHAR);
            else
                add_text(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_traffic();
        int target;
        logic dec;
        logic plus;
        for (int phase = 0; phase < 8; phase++)
        begin
            dec = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
            plus = (phase < 4) ? phase[1] : 1'($urandom_range(0, 1));
            write_reg(CFG_DECODE_MODE, dec);
            write_reg(CFG_PLUS_SPACE, plus);
            if (phase == 5)
                write_reg(CFG_SPARE_HI, 1'($urandom_range(0, 1)));
            gaps_on = (phase % 3 != 2);
            target = sent_items + RANDOM_ITEMS / 8;
            while (sent_items < target)
            begin
                build_text(dec);
                send_text();
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DECODE_MODE;
        cfg_data = 1'b0;
        decoding = 1'b0;
        plus_map = 1'b0;
        hold_cnt = HOLD_NONE;
        hold_char = 8'h00;
        errors = 0;
        sent_items = 0;
        gaps_on = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_encode_directed();
        test_decode_directed();
        test_config_while_held();
        test_random_traffic();
        settle();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
